// File: hdl/tklp_pkg.sv
// tklp_pkg: shared types, codes and constants of the two-key long press controller.
// No dependencies; imported by tklp_cfg, tklp_step and the core top level.
`timescale 1ns / 1ps
`default_nettype none
package tklp_pkg;

	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 16;
	localparam int IDX_BITS  = 3;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [CFG_BITS-1:0]  cfgval_t;

	typedef enum logic [1:0] {
		OP_NONE   = 2'd0,
		OP_OPEN   = 2'd1,
		OP_CLOSE  = 2'd2,
		OP_UNBIND = 2'd3
	} op_code_t;

	typedef enum logic [IDX_BITS-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_LONG_PRESS = 3'd1,
		REG_CHORD_HOLD = 3'd2,
		REG_PRECHARGE  = 3'd3,
		REG_INDICATOR  = 3'd4
	} cfg_reg_t;

	localparam cfgval_t DEBOUNCE_RST   = 16'd50;
	localparam cfgval_t LONG_PRESS_RST = 16'd3000;
	localparam cfgval_t CHORD_HOLD_RST = 16'd2000;
	localparam cfgval_t PRECHARGE_RST  = 16'd2500;
	localparam cfgval_t INDICATOR_RST  = 16'd5000;

	typedef struct packed {
		cfgval_t debounce_ms;
		cfgval_t long_press_ms;
		cfgval_t chord_hold_ms;
		cfgval_t prechg_ms;
		cfgval_t indicator_ms;
	} cfg_t;

	typedef struct packed {
		time_t now_ms;
		logic  key_a;
		logic  key_b;
		logic  key_c;
	} poll_t;

	typedef struct packed {
		logic     stable_a;
		logic     stable_b;
		time_t    change_time_a;
		time_t    change_time_b;
		time_t    press_time_a;
		time_t    press_time_b;
		logic     fired_a;
		logic     fired_b;
		logic     chord_fired;
		logic     chord_armed;
		time_t    chord_start;
		logic     precharge_active;
		time_t    precharge_start;
		op_code_t pending;
		logic     blue_active;
		time_t    blue_start;
		logic     valve_state;
	} state_t;

	typedef struct packed {
		op_code_t deferred_action;
		op_code_t key_action;
		logic     led_a;
		logic     led_b;
		logic     precharging;
		logic     indicator_on;
		logic     valve_open;
		logic     activity;
	} result_t;

	// modular elapsed time
	function automatic time_t since(time_t now, time_t start);
		return now - start;
	endfunction

	function automatic logic reached(time_t elapsed, cfgval_t limit);
		return elapsed >= {{(TIME_BITS-CFG_BITS){1'b0}}, limit};
	endfunction

endpackage
`default_nettype wire

// File: hdl/tklp_cfg.sv
// tklp_cfg: configuration register file written over a valid/ready channel.
// Depends on tklp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tklp_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [tklp_pkg::IDX_BITS-1:0] cfg_index,
	input  wire tklp_pkg::cfgval_t         cfg_data,
	output tklp_pkg::cfg_t                 cfg
);
	import tklp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_PRESS_RST;
			cfg_q.chord_hold_ms <= CHORD_HOLD_RST;
			cfg_q.prechg_ms     <= PRECHARGE_RST;
			cfg_q.indicator_ms  <= INDICATOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data;
				REG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data;
				REG_CHORD_HOLD: cfg_q.chord_hold_ms <= cfg_data;
				REG_PRECHARGE:  cfg_q.prechg_ms     <= cfg_data;
				REG_INDICATOR:  cfg_q.indicator_ms  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/tklp_step.sv
// tklp_step: combinational update of the controller state for one poll.
// Depends on tklp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tklp_step (
	input  wire tklp_pkg::cfg_t    cfg,
	input  wire tklp_pkg::state_t  st,
	input  wire tklp_pkg::poll_t   poll,
	output tklp_pkg::state_t       st_next,
	output tklp_pkg::result_t      res
);
	import tklp_pkg::*;

	time_t now;
	logic  blue_end, pre_end, pre1, pre2;
	logic  chg_a, chg_b, press_a, press_b;
	logic  sa, sb, fa, fb;
	time_t el_pa, el_pb, el_chord;
	logic  chord_hit, long_a, long_b;
	op_code_t deferred, key_act;

	assign now = poll.now_ms;

	always_comb begin
		st_next  = st;
		deferred = OP_NONE;
		key_act  = OP_NONE;

		blue_end = st.blue_active && reached(since(now, st.blue_start), cfg.indicator_ms);
		if (blue_end)
			st_next.blue_active = 1'b0;

		pre_end = st.precharge_active
			&& reached(since(now, st.precharge_start), cfg.prechg_ms);
		pre1 = st.precharge_active && !pre_end;
		if (pre_end) begin
			deferred = st.pending;
			st_next.pending = OP_NONE;
			if (st.pending == OP_OPEN)
				st_next.valve_state = 1'b1;
			else if (st.pending == OP_CLOSE)
				st_next.valve_state = 1'b0;
		end

		// debounce
		chg_a   = (poll.key_a != st.stable_a)
			&& reached(since(now, st.change_time_a), cfg.debounce_ms);
		chg_b   = (poll.key_b != st.stable_b)
			&& reached(since(now, st.change_time_b), cfg.debounce_ms);
		press_a = chg_a && poll.key_a;
		press_b = chg_b && poll.key_b;
		sa = chg_a ? poll.key_a : st.stable_a;
		sb = chg_b ? poll.key_b : st.stable_b;
		fa = chg_a ? 1'b0 : st.fired_a;
		fb = chg_b ? 1'b0 : st.fired_b;
		if (chg_a)
			st_next.change_time_a = now;
		if (chg_b)
			st_next.change_time_b = now;
		if (press_a)
			st_next.press_time_a = now;
		if (press_b)
			st_next.press_time_b = now;
		pre2 = pre1 || press_a || press_b;
		st_next.precharge_active = pre2;
		if ((press_a || press_b) && !pre1)
			st_next.precharge_start = now;
		st_next.stable_a = sa;
		st_next.stable_b = sb;

		el_pa    = press_a ? '0 : since(now, st.press_time_a);
		el_pb    = press_b ? '0 : since(now, st.press_time_b);
		el_chord = st.chord_armed ? since(now, st.chord_start) : '0;

		chord_hit = 1'b0;
		long_a    = 1'b0;
		long_b    = 1'b0;
		if (sa && sb) begin
			if (!st.chord_fired) begin
				st_next.chord_armed = 1'b1;
				if (!st.chord_armed)
					st_next.chord_start = now;
				chord_hit = reached(el_chord, cfg.chord_hold_ms);
				if (chord_hit) begin
					st_next.chord_fired = 1'b1;
					key_act             = OP_UNBIND;
					st_next.blue_active = 1'b1;
					st_next.blue_start  = now;
					st_next.pending     = OP_NONE;
					fa = 1'b1;
					fb = 1'b1;
				end
			end
		end else begin
			st_next.chord_armed = 1'b0;
			st_next.chord_fired = 1'b0;
			long_a = sa && !fa && reached(el_pa, cfg.long_press_ms);
			long_b = sb && !fb && reached(el_pb, cfg.long_press_ms);
			if (long_a) begin
				fa = 1'b1;
				if (!pre2) begin
					st_next.valve_state = 1'b1;
					key_act = OP_OPEN;
				end else begin
					st_next.pending = OP_OPEN;
				end
			end
			if (long_b) begin
				fb = 1'b1;
				if (!pre2) begin
					st_next.valve_state = 1'b0;
					key_act = OP_CLOSE;
				end else begin
					st_next.pending = OP_CLOSE;
				end
			end
		end
		st_next.fired_a = fa;
		st_next.fired_b = fb;
	end

	always_comb begin
		res.deferred_action = deferred;
		res.key_action      = key_act;
		res.led_a           = st_next.stable_a;
		res.led_b           = st_next.stable_b;
		res.precharging     = st_next.precharge_active;
		res.indicator_on    = st_next.blue_active;
		res.valve_open      = st_next.valve_state;
		res.activity        = poll.key_a | poll.key_b | poll.key_c;
	end

endmodule
`default_nettype wire

// File: hdl/two_key_long_press_controller_core.sv
// two_key_long_press_controller_core: top level with input register, state and result register.
// Depends on tklp_pkg, tklp_cfg and tklp_step.
`timescale 1ns / 1ps
`default_nettype none
// Poll-driven two-key controller: debounce, long press open/close, two-key chord unbind,
// precharge window with deferred action and blue indicator window. One request in, one
// result out. A poll is taken every clock unless in_stall is high; each result passes the
// input register, then the result register, and can be held by out_stall. The clock is set
// by the 32-bit elapsed-time subtract and compare feeding the state update in tklp_step.
// One new poll is taken while a finished result still waits on out_stall. Configuration
// registers are to be written over cfg_valid/cfg_ready only while the block is idle; the
// block itself does not enforce this. cfg_ready is always high.
module two_key_long_press_controller_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [tklp_pkg::TIME_BITS-1:0] now_ms,
	input  wire logic                          key_a_raw,
	input  wire logic                          key_b_raw,
	input  wire logic                          key_c_raw,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [1:0]                         deferred_action,
	output logic [1:0]                         key_action,
	output logic                               led_a,
	output logic                               led_b,
	output logic                               precharging,
	output logic                               indicator_on,
	output logic                               valve_open,
	output logic                               activity,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tklp_pkg::IDX_BITS-1:0] cfg_index,
	input  wire logic [tklp_pkg::CFG_BITS-1:0] cfg_data
);
	import tklp_pkg::*;

	cfg_t    cfg;
	poll_t   poll_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	state_t  st_q;
	state_t  st_next;
	result_t res;
	logic    advance;
	logic    accept;

	tklp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tklp_step u_step (
		.cfg     (cfg),
		.st      (st_q),
		.poll    (poll_s1),
		.st_next (st_next),
		.res     (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			poll_s1.now_ms <= now_ms;
			poll_s1.key_a  <= key_a_raw;
			poll_s1.key_b  <= key_b_raw;
			poll_s1.key_c  <= key_c_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	assign out_valid       = valid_s2;
	assign deferred_action = res_s2.deferred_action;
	assign key_action      = res_s2.key_action;
	assign led_a           = res_s2.led_a;
	assign led_b           = res_s2.led_b;
	assign precharging     = res_s2.precharging;
	assign indicator_on    = res_s2.indicator_on;
	assign valve_open      = res_s2.valve_open;
	assign activity        = res_s2.activity;

`ifndef SYNTHESIS
	a_unbind_lights: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.key_action == OP_UNBIND |-> indicator_on)
		else $error("unbind without indicator");

	a_open_sets_valve: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.key_action == OP_OPEN |-> valve_open && !precharging)
		else $error("open result inconsistent");

	a_close_clears_valve: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && res_s2.key_action == OP_CLOSE |-> !valve_open && !precharging)
		else $error("close result inconsistent");

	a_no_state_move_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(st_q))
		else $error("state changed without a request");
`endif

endmodule
`default_nettype wire
